@@ design/gpuf_pkg.sv @@
// ---------------------------------------------------------------------------
// gpuf_pkg: shared types and constants for the grid percolation core
// Command/status bundles between controller and datapath, codes, defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpuf_pkg;

	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 32;

	localparam int CFG_W = 6;   // configuration register width
	localparam int CNT_W = 11;  // open count width
	localparam int POS_W = 5;   // row / col field width

	localparam logic       FUNC_OPEN  = 1'b0;
	localparam logic       FUNC_CLEAR = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam logic       REG_HEIGHT = 1'b0;
	localparam logic       REG_WIDTH  = 1'b1;

	typedef enum logic [1:0] {
		SRC_CELL   = 2'd0,
		SRC_OTHER  = 2'd1,
		SRC_TOP    = 2'd2,
		SRC_BOTTOM = 2'd3
	} walk_src_t;

	typedef struct packed {
		logic      load;
		logic      sweep_step;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      oaddr_other;
		logic      open_wr;
		logic      set_dup;
		logic      k_clr;
		logic      k_inc;
		logic      other_load;
		logic      walk_load;
		walk_src_t walk_src;
		logic      walk_step;
		logic      save_ra;
		logic      save_rb;
		logic      link;
		logic      perc_set;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic bad_cell;
		logic odata;
		logic cand_take;
		logic k_last;
		logic root_hit;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

@@ design/gpuf_ctrl.sv @@
// ---------------------------------------------------------------------------
// gpuf_ctrl: sequencer for the grid percolation core
// Steps clear sweeps, open checks, the six join candidates and root walks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpuf_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire             func,
	input  gpuf_pkg::stat_t stat,
	output gpuf_pkg::cmd_t  cmd
);
	import gpuf_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_SWEEP = 12'b000000000010,
		S_ORD   = 12'b000000000100,
		S_OEV   = 12'b000000001000,
		S_CAND  = 12'b000000010000,
		S_CRD   = 12'b000000100000,
		S_CEV   = 12'b000001000000,
		S_WRD   = 12'b000010000000,
		S_WCMP  = 12'b000100000000,
		S_LINK  = 12'b001000000000,
		S_PERC  = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	typedef enum logic [1:0] {
		PH_A   = 2'd0,
		PH_B   = 2'd1,
		PH_T   = 2'd2,
		PH_BOT = 2'd3
	} phase_t;

	state_t state_q, state_d;
	phase_t ph_q, ph_d;
	logic   init_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ph_d    = ph_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (func == FUNC_CLEAR) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_SWEEP;
					end else begin
						state_d = S_ORD;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					if (init_q) begin
						// the sweep after reset has no word to answer
						state_d = S_IDLE;
					end else begin
						cmd.walk_load = 1'b1;
						cmd.walk_src  = SRC_TOP;
						ph_d          = PH_T;
						state_d       = S_WRD;
					end
				end
			end
			S_ORD: begin
				if (stat.bad_cell) begin
					cmd.walk_load = 1'b1;
					cmd.walk_src  = SRC_TOP;
					ph_d          = PH_T;
					state_d       = S_WRD;
				end else begin
					state_d = S_OEV;
				end
			end
			S_OEV: begin
				if (stat.odata) begin
					cmd.set_dup   = 1'b1;
					cmd.walk_load = 1'b1;
					cmd.walk_src  = SRC_TOP;
					ph_d          = PH_T;
					state_d       = S_WRD;
				end else begin
					cmd.open_wr = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.k_clr   = 1'b1;
					state_d     = S_CAND;
				end
			end
			S_CAND: begin
				cmd.other_load = 1'b1;
				state_d        = S_CRD;
			end
			S_CRD: begin
				cmd.oaddr_other = 1'b1;
				state_d         = S_CEV;
			end
			S_CEV: begin
				if (stat.cand_take) begin
					cmd.walk_load = 1'b1;
					cmd.walk_src  = SRC_CELL;
					ph_d          = PH_A;
					state_d       = S_WRD;
				end else if (stat.k_last) begin
					cmd.walk_load = 1'b1;
					cmd.walk_src  = SRC_TOP;
					ph_d          = PH_T;
					state_d       = S_WRD;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_CAND;
				end
			end
			S_WRD: begin
				state_d = S_WCMP;
			end
			S_WCMP: begin
				if (stat.root_hit) begin
					case (ph_q)
						PH_A: begin
							cmd.save_ra   = 1'b1;
							cmd.walk_load = 1'b1;
							cmd.walk_src  = SRC_OTHER;
							ph_d          = PH_B;
							state_d       = S_WRD;
						end
						PH_B: begin
							cmd.save_rb = 1'b1;
							state_d     = S_LINK;
						end
						PH_T: begin
							cmd.save_ra   = 1'b1;
							cmd.walk_load = 1'b1;
							cmd.walk_src  = SRC_BOTTOM;
							ph_d          = PH_BOT;
							state_d       = S_WRD;
						end
						default: begin
							cmd.save_rb = 1'b1;
							state_d     = S_PERC;
						end
					endcase
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_WRD;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				if (stat.k_last) begin
					cmd.walk_load = 1'b1;
					cmd.walk_src  = SRC_TOP;
					ph_d          = PH_T;
					state_d       = S_WRD;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = S_CAND;
				end
			end
			S_PERC: begin
				cmd.perc_set = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// reset starts with a sweep that sets up the parent and open stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			ph_q    <= PH_A;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			if (state_q == S_SWEEP && stat.sweep_last) init_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ design/gpuf_dp.sv @@
// ---------------------------------------------------------------------------
// gpuf_dp: datapath of the grid percolation core
// Parent and open-bit memories, root walker, candidate select, result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpuf_dp #(
	parameter int MAX_ROWS = gpuf_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gpuf_pkg::DEF_MAX_COLS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  gpuf_pkg::cmd_t                    cmd,
	output gpuf_pkg::stat_t                   stat,
	input  wire                               cfg_valid,
	input  wire                               cfg_index,
	input  wire  [gpuf_pkg::CFG_W-1:0]        cfg_data,
	input  wire  [gpuf_pkg::POS_W-1:0]        row,
	input  wire  [gpuf_pkg::POS_W-1:0]        col,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              percolates,
	output logic [gpuf_pkg::CNT_W-1:0]        open_count,
	output logic [1:0]                        status
);
	import gpuf_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int NODES = CELLS + 2;
	localparam int NW    = $clog2(NODES);
	localparam int CW    = $clog2(CELLS);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int LW    = $clog2(MAX_COLS + 1);
	localparam int SW0   = (RW > LW) ? RW : LW;
	localparam int SW1   = (SW0 > CFG_W) ? SW0 : CFG_W;
	localparam int SW    = (SW1 > POS_W) ? SW1 + 1 : POS_W + 1;

	localparam logic [NW-1:0] TOP_NODE = NW'(CELLS);
	localparam logic [NW-1:0] BOT_NODE = NW'(CELLS + 1);
	localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

	logic [NW-1:0] pmem [NODES];
	logic          omem [CELLS];

	logic [CFG_W-1:0] gh_q, gw_q;
	logic [SW-1:0]    h_q, w_q, row_q, col_q;
	logic [NW-1:0]    cell_q, other_q, cur_q, ra_q, rb_q, sweep_q;
	logic [2:0]       k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       st_q;
	logic             perc_q;
	logic [NW-1:0]    pdata_q;
	logic             odata_q;

	logic [SW-1:0] h_eff, w_eff, row_x, col_x;
	logic [NW-1:0] cell_d, cand_node, walk_init;
	logic          cand_ok, cand_nb;
	logic [CW-1:0] oaddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gh_q <= CFG_W'(32);
			gw_q <= CFG_W'(32);
		end else if (cfg_valid) begin
			if (cfg_index == REG_HEIGHT) gh_q <= cfg_data;
			else                          gw_q <= cfg_data;
		end
	end

	// register value 0 acts as 1, above the maximum acts as the maximum
	always_comb begin
		if (gh_q == '0)                         h_eff = SW'(1);
		else if (SW'(gh_q) > SW'(MAX_ROWS))     h_eff = SW'(MAX_ROWS);
		else                                    h_eff = SW'(gh_q);
		if (gw_q == '0)                         w_eff = SW'(1);
		else if (SW'(gw_q) > SW'(MAX_COLS))     w_eff = SW'(MAX_COLS);
		else                                    w_eff = SW'(gw_q);
		row_x  = SW'(row);
		col_x  = SW'(col);
		cell_d = NW'(NW'(row) * NW'(MAX_COLS) + NW'(col));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q    <= h_eff;
			w_q    <= w_eff;
			row_q  <= row_x;
			col_q  <= col_x;
			cell_q <= cell_d;
		end
	end

	// a clear word always reports done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_DONE;
		end else if (cmd.load) begin
			st_q <= (!cmd.cnt_clr && (row_x >= h_eff || col_x >= w_eff)) ? ST_OUT : ST_DONE;
		end else if (cmd.set_dup) begin
			st_q <= ST_DUP;
		end
	end

	// join candidates: top node, bottom node, right, left, down, up
	always_comb begin
		cand_ok   = 1'b0;
		cand_nb   = 1'b1;
		cand_node = cell_q;
		case (k_q)
			3'd0: begin
				cand_ok   = (row_q == '0);
				cand_nb   = 1'b0;
				cand_node = TOP_NODE;
			end
			3'd1: begin
				cand_ok   = (row_q == h_q - SW'(1));
				cand_nb   = 1'b0;
				cand_node = BOT_NODE;
			end
			3'd2: begin
				cand_ok   = (col_q + SW'(1) < w_q);
				cand_node = cell_q + NW'(1);
			end
			3'd3: begin
				cand_ok   = (col_q != '0);
				cand_node = cell_q - NW'(1);
			end
			3'd4: begin
				cand_ok   = (row_q + SW'(1) < h_q);
				cand_node = cell_q + NW'(MAX_COLS);
			end
			3'd5: begin
				cand_ok   = (row_q != '0);
				cand_node = cell_q - NW'(MAX_COLS);
			end
			default: begin
				cand_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.other_load) other_q <= cand_node;
	end

	always_comb begin
		case (cmd.walk_src)
			SRC_CELL:   walk_init = cell_q;
			SRC_OTHER:  walk_init = other_q;
			SRC_TOP:    walk_init = TOP_NODE;
			default:    walk_init = BOT_NODE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_load)      cur_q <= walk_init;
		else if (cmd.walk_step) cur_q <= pdata_q;
		if (cmd.save_ra) ra_q <= cur_q;
		if (cmd.save_rb) rb_q <= cur_q;
	end

	// parent store: one write, one registered read at the walk pointer
	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			pmem[sweep_q] <= sweep_q;
		end else if (cmd.link && ra_q != rb_q) begin
			pmem[ra_q] <= rb_q;
		end
		pdata_q <= pmem[cur_q];
	end

	assign oaddr = cmd.oaddr_other ? other_q[CW-1:0] : cell_q[CW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			if (sweep_q < NW'(CELLS)) omem[sweep_q[CW-1:0]] <= 1'b0;
		end else if (cmd.open_wr) begin
			omem[cell_q[CW-1:0]] <= 1'b1;
		end
		odata_q <= omem[oaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_q <= (sweep_q == LAST_NODE) ? '0 : sweep_q + NW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.perc_set) perc_q <= (ra_q == rb_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			percolates <= perc_q;
			open_count <= cnt_q;
			status     <= st_q;
		end
	end

	assign stat.sweep_last = (sweep_q == LAST_NODE);
	assign stat.bad_cell   = (st_q != ST_DONE);
	assign stat.odata      = odata_q;
	assign stat.cand_take  = cand_ok && (!cand_nb || odata_q);
	assign stat.k_last     = (k_q == 3'd5);
	assign stat.root_hit   = (pdata_q == cur_q);
	assign stat.out_busy   = out_valid && !out_ready;

endmodule

`default_nettype wire

@@ design/grid_percolation_union_find_core.sv @@
// ---------------------------------------------------------------------------
// grid_percolation_union_find_core: percolation tracker on a union-find store
// Opens grid cells, joins open neighbors, reports top-to-bottom connection.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: func, row, col. func 0
// opens a cell, func 1 clears the grid. Each word gives one result word on
// the output channel: percolates, open_count, status.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets rows and columns
// in use; it is always ready and should be written while the core is idle.
// One word at a time. An open checks each join candidate; for each one
// taken it walks both parent chains to their roots and links them, then
// does a final top/bottom walk; chain depth in the parent memory sets latency.
// Ignored opens skip the candidates and go straight to the final walk.
// A clear sweeps all MAX_ROWS*MAX_COLS+2 parent entries, then reports.
// After reset the same sweep runs before in_ready.
// Results sit in an output register; while the receiver stalls the core
// may still take the next word and stops only when a second result is ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_percolation_union_find_core #(
	parameter int MAX_ROWS = gpuf_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gpuf_pkg::DEF_MAX_COLS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        func,
	input  wire  [gpuf_pkg::POS_W-1:0] row,
	input  wire  [gpuf_pkg::POS_W-1:0] col,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic                       percolates,
	output logic [gpuf_pkg::CNT_W-1:0] open_count,
	output logic [1:0]                 status,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire                        cfg_index,
	input  wire  [gpuf_pkg::CFG_W-1:0] cfg_data
);
	import gpuf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	gpuf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.stat     (stat),
		.cmd      (cmd)
	);

	gpuf_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.row        (row),
		.col        (col),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.percolates (percolates),
		.open_count (open_count),
		.status     (status)
	);

endmodule

`default_nettype wire

@@ design/gpuf_chk.sv @@
// ---------------------------------------------------------------------------
// gpuf_chk: port checker for the grid percolation core
// Watches handshakes and result words at the top-level ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpuf_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire                        percolates,
	input wire [gpuf_pkg::CNT_W-1:0]  open_count,
	input wire [1:0]                  status
);
	import gpuf_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(open_count)
			&& $stable(status) && $stable(percolates))
		else $error("result word changed while stalled");

	// one word in flight: ready drops after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_DONE || status == ST_DUP || status == ST_OUT)
		else $error("bad status code");

	// an empty grid cannot percolate
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_count == '0 |-> !percolates)
		else $error("percolation with no open cells");

endmodule

bind grid_percolation_union_find_core gpuf_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.percolates (percolates),
	.open_count (open_count),
	.status     (status)
);

`default_nettype wire
